// File: hdl/tlbrm_pkg.sv
package tlbrm_pkg;

  // Table geometry.
  localparam int unsigned TlbEntries = 64;
  localparam int unsigned IdxW       = $clog2(TlbEntries);
  localparam int unsigned PageW      = 22;
  localparam int unsigned OffW       = 10;

  // Request operation codes.
  localparam logic OpAdd    = 1'b0;
  localparam logic OpRemove = 1'b1;

  // Result status codes.
  localparam logic [1:0] StsWritten     = 2'd0;
  localparam logic [1:0] StsInvalidated = 2'd1;
  localparam logic [1:0] StsNothing     = 2'd2;
  localparam logic [1:0] StsError       = 2'd3;

  // Error codes.
  localparam logic [1:0] ErrNone   = 2'd0;
  localparam logic [1:0] ErrNoFree = 2'd1;
  localparam logic [1:0] ErrNoFit  = 2'd2;

  // One request as it arrives on the input channel.
  typedef struct packed {
    logic        op;
    logic [31:0] phys_base;
    logic [31:0] virt_base;
    logic [31:0] length;
    logic        inhibit_cache;
  } tlb_req_t;

  // One result on the output channel.
  typedef struct packed {
    logic [1:0]  status;
    logic [1:0]  error;
    logic [5:0]  entry_index;
    logic [31:0] chunk_phys;
    logic [31:0] chunk_virt;
    logic [2:0]  size_code;
    logic        last;
  } tlb_rsp_t;

  // Contents of one table entry held in the memory.
  typedef struct packed {
    logic [PageW-1:0] virt_page;
    logic [PageW-1:0] phys_page;
    logic [2:0]       size;
    logic             inhibit;
  } tlb_entry_t;

  // Chunk size in bytes for each size code.
  function automatic logic [31:0] chunk_bytes(input logic [2:0] code);
    logic [31:0] res;
    case (code)
      3'd0:    res = 32'h0000_0400;
      3'd1:    res = 32'h0000_1000;
      3'd2:    res = 32'h0000_4000;
      3'd3:    res = 32'h0001_0000;
      3'd4:    res = 32'h0004_0000;
      3'd5:    res = 32'h0010_0000;
      3'd6:    res = 32'h0100_0000;
      default: res = 32'h1000_0000;
    endcase
    return res;
  endfunction

endpackage

// File: hdl/tlb_region_mapper_unit.sv
// Translation table of TlbEntries entries, filled and cleared one region per
// request. An add request splits its region into aligned chunks, largest first,
// and writes each chunk into the lowest free entry; it gives one result per
// chunk, or a single result when nothing is written. A remove request
// invalidates every valid entry lying wholly inside the virtual range and gives
// one result per entry removed, or a single result when none matches. The final
// result of a request carries last, and an add that runs out of entries or of
// fitting sizes reports the error there. Requests are handled one at a time.
// An add alternates between picking the size of each chunk and a scan for the
// lowest free entry, a serial walk over the valid bits that visits up to
// TlbEntries entries, and ends with the size check that ends the walk and then
// the closing result. A remove reads each entry in turn through the single
// registered read port of the entry memory and then checks it. One result
// can wait at the output and one more can be staged behind it; the walk stalls
// when a further result is due while both are full, and the closing result
// waits for a free output.
// The table comes out of reset empty; no clearing pass is needed.
module tlb_region_mapper_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  tlbrm_pkg::tlb_req_t in_req_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output tlbrm_pkg::tlb_rsp_t out_rsp_o
);
  import tlbrm_pkg::*;

  typedef enum logic [2:0] {
    StIdle,
    StAddSize,
    StAddScan,
    StRemRead,
    StRemCheck,
    StFinish
  } state_e;

  localparam logic [IdxW-1:0] IdxLast = IdxW'(TlbEntries - 1);

  state_e            state_q, state_d;
  logic [IdxW-1:0]   idx_q, idx_d;
  logic [31:0]       phys_q, phys_d;
  logic [31:0]       virt_q, virt_d;
  logic [31:0]       len_q, len_d;
  logic [31:0]       range_end_q, range_end_d;
  logic              inh_q, inh_d;
  logic [2:0]        code_q, code_d;
  logic [1:0]        err_q, err_d;
  logic [TlbEntries-1:0] valid_q, valid_d;
  tlb_rsp_t          hold_q, hold_d;
  logic              hold_valid_q, hold_valid_d;
  tlb_rsp_t          out_q, out_d;
  logic              out_valid_q, out_valid_d;

  tlb_entry_t        mem_q [TlbEntries];
  tlb_entry_t        rd_q;
  logic              mem_we;
  tlb_entry_t        mem_wdata;

  logic              fit_found;
  logic [2:0]        fit_code;
  logic [31:0]       chunk_sz;
  logic [31:0]       ent_virt;
  logic [31:0]       ent_end;
  logic              rem_hit;
  logic              out_free;
  logic              can_push;
  tlb_rsp_t          new_rsp;

  // Largest chunk size that the physical address and remaining length allow.
  always_comb begin
    logic [31:0] sz;
    fit_found = 1'b0;
    fit_code  = '0;
    for (int c = 0; c < 8; c++) begin
      sz = chunk_bytes(3'(c));
      if (((phys_q & (sz - 32'd1)) == 32'd0) && (len_q >= sz)) begin
        fit_found = 1'b1;
        fit_code  = 3'(c);
      end
    end
  end

  assign chunk_sz = chunk_bytes(code_q);

  // Range check of the entry read back from the memory.
  assign ent_virt = {rd_q.virt_page, {OffW{1'b0}}};
  assign ent_end  = ent_virt + chunk_bytes(rd_q.size) - 32'd1;
  assign rem_hit  = valid_q[idx_q] && (ent_virt >= virt_q) && (ent_end <= range_end_q);

  // A new result may be produced when no result is held or the held one can move to the output.
  assign out_free = !out_valid_q || !out_stall_i;
  assign can_push = !hold_valid_q || out_free;

  // Request sequencing and result staging.
  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    phys_d       = phys_q;
    virt_d       = virt_q;
    len_d        = len_q;
    range_end_d  = range_end_q;
    inh_d        = inh_q;
    code_d       = code_q;
    err_d        = err_q;
    valid_d      = valid_q;
    hold_d       = hold_q;
    hold_valid_d = hold_valid_q;
    out_d        = out_q;
    out_valid_d  = out_valid_q && out_stall_i;
    mem_we       = 1'b0;
    mem_wdata    = '{virt_page: virt_q[31:OffW], phys_page: phys_q[31:OffW],
                     size: code_q, inhibit: inh_q};
    new_rsp      = '0;

    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          phys_d      = in_req_i.phys_base;
          virt_d      = in_req_i.virt_base;
          len_d       = in_req_i.length;
          inh_d       = in_req_i.inhibit_cache;
          range_end_d = in_req_i.virt_base + in_req_i.length - 32'd1;
          err_d       = ErrNone;
          idx_d       = '0;
          state_d     = (in_req_i.op == OpAdd) ? StAddSize : StRemRead;
        end
      end

      StAddSize: begin
        if (len_q == 32'd0) begin
          state_d = StFinish;
        end else if (!fit_found) begin
          err_d   = ErrNoFit;
          state_d = StFinish;
        end else begin
          code_d  = fit_code;
          idx_d   = '0;
          state_d = StAddScan;
        end
      end

      StAddScan: begin
        if (!valid_q[idx_q]) begin
          if (can_push) begin
            mem_we                = 1'b1;
            valid_d[idx_q]        = 1'b1;
            new_rsp.status        = StsWritten;
            new_rsp.error         = ErrNone;
            new_rsp.entry_index   = 6'(idx_q);
            new_rsp.chunk_phys    = {phys_q[31:OffW], {OffW{1'b0}}};
            new_rsp.chunk_virt    = {virt_q[31:OffW], {OffW{1'b0}}};
            new_rsp.size_code     = code_q;
            new_rsp.last          = 1'b0;
            if (hold_valid_q) begin
              out_d       = hold_q;
              out_valid_d = 1'b1;
            end
            hold_d       = new_rsp;
            hold_valid_d = 1'b1;
            len_d        = len_q - chunk_sz;
            phys_d       = phys_q + chunk_sz;
            virt_d       = virt_q + chunk_sz;
            state_d      = StAddSize;
          end
        end else if (idx_q == IdxLast) begin
          err_d   = ErrNoFree;
          state_d = StFinish;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end

      StRemRead: begin
        state_d = StRemCheck;
      end

      StRemCheck: begin
        if (!rem_hit || can_push) begin
          if (rem_hit) begin
            valid_d[idx_q]      = 1'b0;
            new_rsp.status      = StsInvalidated;
            new_rsp.error       = ErrNone;
            new_rsp.entry_index = 6'(idx_q);
            new_rsp.chunk_phys  = {rd_q.phys_page, {OffW{1'b0}}};
            new_rsp.chunk_virt  = ent_virt;
            new_rsp.size_code   = rd_q.size;
            new_rsp.last        = 1'b0;
            if (hold_valid_q) begin
              out_d       = hold_q;
              out_valid_d = 1'b1;
            end
            hold_d       = new_rsp;
            hold_valid_d = 1'b1;
          end
          if (idx_q == IdxLast) begin
            state_d = StFinish;
          end else begin
            idx_d   = idx_q + 1'b1;
            state_d = StRemRead;
          end
        end
      end

      StFinish: begin
        if (out_free) begin
          if (hold_valid_q) begin
            out_d       = hold_q;
            out_d.error = err_q;
          end else begin
            out_d        = '0;
            out_d.status = (err_q != ErrNone) ? StsError : StsNothing;
            out_d.error  = err_q;
          end
          out_d.last   = 1'b1;
          out_valid_d  = 1'b1;
          hold_valid_d = 1'b0;
          state_d      = StIdle;
        end
      end

      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Control and result registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      valid_q      <= '0;
      hold_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      valid_q      <= valid_d;
      hold_valid_q <= hold_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Working registers of the current request.
  always_ff @(posedge clk_i) begin
    idx_q       <= idx_d;
    phys_q      <= phys_d;
    virt_q      <= virt_d;
    len_q       <= len_d;
    range_end_q <= range_end_d;
    inh_q       <= inh_d;
    code_q      <= code_d;
    err_q       <= err_d;
    hold_q      <= hold_d;
    out_q       <= out_d;
  end

  // Entry memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[idx_q] <= mem_wdata;
    end
    rd_q <= mem_q[idx_q];
  end

  assign in_stall_o  = (state_q != StIdle);
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

`ifndef SYNTHESIS
  // No result is left staged once the block is back to idle.
  a_hold_empty_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StIdle |-> !hold_valid_q)
    else $error("staged result left over in idle");

  // A chunk is only ever written into a free entry.
  a_write_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> !valid_q[idx_q])
    else $error("entry overwritten while valid");

  // A written entry is valid in the next cycle.
  a_write_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |=> valid_q[$past(idx_q)])
    else $error("written entry not marked valid");

  // Status without an entry only appears on the final result.
  a_lone_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_rsp_o.status == StsNothing || out_rsp_o.status == StsError)
      |-> out_rsp_o.last)
    else $error("nothing-done or error result without last");

  // An error only ever closes a request.
  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_rsp_o.error != ErrNone) |-> out_rsp_o.last)
    else $error("error reported before the final result");
`endif

endmodule

// File: tb/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import tlbrm_pkg::*;

  // Size codes of a table entry.
  localparam logic [2:0] Size1K   = 3'd0;
  localparam logic [2:0] Size4K   = 3'd1;
  localparam logic [2:0] Size16K  = 3'd2;
  localparam logic [2:0] Size64K  = 3'd3;
  localparam logic [2:0] Size256K = 3'd4;
  localparam logic [2:0] Size1M   = 3'd5;
  localparam logic [2:0] Size16M  = 3'd6;
  localparam logic [2:0] Size256M = 3'd7;

  localparam int unsigned RandomPerPhase = 100;
  localparam int unsigned TailCycles     = 300;
  localparam int unsigned CycleLimit     = 10_000_000;

  logic     clk_i     = 1'b0;
  logic     rst_ni    = 1'b0;
  logic     req_valid = 1'b0;
  logic     req_stall;
  tlb_req_t req_data  = '0;
  logic     rsp_valid;
  logic     rsp_stall = 1'b0;
  tlb_rsp_t rsp_data;
  logic     took_req  = 1'b0;

  int unsigned send_idle_pct = 26;
  int unsigned recv_idle_pct = 71;

  // Requests waiting to be driven, and results the table is due to give.
  tlb_req_t req_backlog[$];
  tlb_rsp_t results_due[$];
  // Recently generated adds, used to aim removes at mapped regions.
  tlb_req_t recent_adds[$];

  // Predicted contents of the translation table.
  logic       tbl_valid[TlbEntries];
  tlb_entry_t tbl[TlbEntries];

  int unsigned mismatches  = 0;
  int unsigned rsp_checked = 0;
  int unsigned n_add       = 0;
  int unsigned n_remove    = 0;
  int unsigned n_add_err   = 0;
  int unsigned cycle_count = 0;

  tlb_region_mapper_unit u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_valid),
    .in_stall_o  (req_stall),
    .in_req_i    (req_data),
    .out_valid_o (rsp_valid),
    .out_stall_i (rsp_stall),
    .out_rsp_o   (rsp_data)
  );

  always #6 clk_i = ~clk_i;

  // Bytes covered by a chunk of the given size.
  function automatic logic [31:0] chunk_span(input logic [2:0] code);
    logic [31:0] bytes;
    case (code)
      Size1K:   bytes = 32'h0000_0400;
      Size4K:   bytes = 32'h0000_1000;
      Size16K:  bytes = 32'h0000_4000;
      Size64K:  bytes = 32'h0001_0000;
      Size256K: bytes = 32'h0004_0000;
      Size1M:   bytes = 32'h0010_0000;
      Size16M:  bytes = 32'h0100_0000;
      default:  bytes = 32'h1000_0000;
    endcase
    return bytes;
  endfunction

  function automatic string rsp_text(input tlb_rsp_t r);
    return $sformatf("sts=%0d err=%0d idx=%0d phys=%08h virt=%08h size=%0d last=%0d",
                     r.status, r.error, r.entry_index, r.chunk_phys, r.chunk_virt,
                     r.size_code, r.last);
  endfunction

  // Cover a region with aligned chunks, largest first, each in the lowest free entry.
  function automatic void map_region(input tlb_req_t r);
    logic [31:0] phys, virt, len, span;
    logic [1:0]  err;
    int          code, slot, c, i, count;
    tlb_rsp_t    held;
    phys  = r.phys_base;
    virt  = r.virt_base;
    len   = r.length;
    err   = ErrNone;
    count = 0;
    held  = '0;
    while (len != 32'd0 && err == ErrNone) begin
      code = -1;
      for (c = int'(Size256M); c >= int'(Size1K); c--) begin
        if (code < 0 && (phys & (chunk_span(3'(c)) - 32'd1)) == 32'd0 &&
            len >= chunk_span(3'(c))) begin
          code = c;
        end
      end
      slot = -1;
      for (i = 0; i < TlbEntries; i++) begin
        if (slot < 0 && !tbl_valid[i]) slot = i;
      end
      if (code < 0) begin
        err = ErrNoFit;
      end else if (slot < 0) begin
        err = ErrNoFree;
      end else begin
        // The previous chunk is now known not to be the final one.
        if (count != 0) results_due.push_back(held);
        span                 = chunk_span(3'(code));
        tbl_valid[slot]      = 1'b1;
        tbl[slot].virt_page  = virt[31:10];
        tbl[slot].phys_page  = phys[31:10];
        tbl[slot].size       = 3'(code);
        tbl[slot].inhibit    = r.inhibit_cache;
        held                 = '0;
        held.status          = StsWritten;
        held.entry_index     = 6'(slot);
        held.chunk_phys      = {phys[31:10], 10'b0};
        held.chunk_virt      = {virt[31:10], 10'b0};
        held.size_code       = 3'(code);
        count++;
        len  = len - span;
        phys = phys + span;
        virt = virt + span;
      end
    end
    if (count == 0) begin
      held        = '0;
      held.status = (err != ErrNone) ? StsError : StsNothing;
    end
    if (err != ErrNone) n_add_err++;
    held.error = err;
    held.last  = 1'b1;
    results_due.push_back(held);
  endfunction

  // Invalidate every valid entry lying wholly inside the virtual range.
  function automatic void unmap_range(input tlb_req_t r);
    logic [31:0] range_end, tv, tend;
    int          i, count;
    tlb_rsp_t    held;
    range_end = r.virt_base + r.length - 32'd1;
    count     = 0;
    held      = '0;
    for (i = 0; i < TlbEntries; i++) begin
      if (tbl_valid[i]) begin
        tv   = {tbl[i].virt_page, 10'b0};
        tend = tv + chunk_span(tbl[i].size) - 32'd1;
        if (tv >= r.virt_base && tend <= range_end) begin
          if (count != 0) results_due.push_back(held);
          tbl_valid[i]     = 1'b0;
          held             = '0;
          held.status      = StsInvalidated;
          held.entry_index = 6'(i);
          held.chunk_phys  = {tbl[i].phys_page, 10'b0};
          held.chunk_virt  = tv;
          held.size_code   = tbl[i].size;
          count++;
        end
      end
    end
    if (count == 0) begin
      held        = '0;
      held.status = StsNothing;
    end
    held.last = 1'b1;
    results_due.push_back(held);
  endfunction

  task automatic queue_req(input logic op, input logic [31:0] phys, input logic [31:0] virt,
                           input logic [31:0] len, input logic inh);
    tlb_req_t r;
    r.op            = op;
    r.phys_base     = phys;
    r.virt_base     = virt;
    r.length        = len;
    r.inhibit_cache = inh;
    req_backlog.push_back(r);
  endtask

  // Mostly well-formed adds and removes aimed at earlier adds, with some noise.
  function automatic tlb_req_t random_req();
    tlb_req_t    r;
    int unsigned pick, s, a, k;
    logic [31:0] mask;
    r.op            = OpAdd;
    r.phys_base     = $urandom;
    r.virt_base     = $urandom;
    r.length        = $urandom;
    r.inhibit_cache = 1'($urandom_range(1));
    pick            = $urandom_range(99);
    if (pick < 10) begin
      r.op = 1'($urandom_range(1));
    end else if (pick < 62) begin
      s    = (pick < 56) ? $urandom_range(int'(Size256K)) : $urandom_range(int'(Size256M));
      a    = ($urandom_range(3) == 0) ? $urandom_range(int'(Size256M)) : s;
      mask = chunk_span(3'(a)) - 32'd1;
      r.phys_base = r.phys_base & ~mask;
      if ($urandom_range(4) != 0) r.virt_base = r.virt_base & ~mask;
      r.length = chunk_span(3'(s)) * $urandom_range(1, 3);
      if ($urandom_range(3) == 0) r.length = r.length + $urandom_range(2047);
      if ($urandom_range(29) == 0) r.length = '0;
      recent_adds.push_back(r);
      if (recent_adds.size() > 16) void'(recent_adds.pop_front());
    end else if (pick < 66) begin
      // Zero length from address zero wraps to the whole space.
      r.op        = OpRemove;
      r.virt_base = '0;
      r.length    = '0;
    end else begin
      r.op = OpRemove;
      if (recent_adds.size() != 0 && pick < 90) begin
        k           = $urandom_range(recent_adds.size() - 1);
        r.virt_base = recent_adds[k].virt_base & ~32'h3FF;
        r.length    = recent_adds[k].length + $urandom_range(32'h4000);
        if ($urandom_range(3) == 0) begin
          r.virt_base = r.virt_base - $urandom_range(32'h4000);
          r.length    = r.length + 32'h4000;
        end
        // A range one byte short leaves the last chunk in place.
        if ($urandom_range(3) == 0) r.length = recent_adds[k].length - 32'd1;
      end
    end
    return r;
  endfunction

  // Driver: present the next request at the falling edge, hold it until taken.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!req_valid || took_req) begin
        if (req_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          req_data  <= req_backlog.pop_front();
          req_valid <= 1'b1;
        end else begin
          req_valid <= 1'b0;
        end
      end
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Monitor: predict each accepted request and check each accepted result.
  always @(posedge clk_i) begin : observe
    tlb_rsp_t want;
    if (rst_ni) begin
      took_req <= req_valid && !req_stall;
      if (req_valid && !req_stall) begin
        if (req_data.op == OpAdd) begin
          n_add++;
          map_region(req_data);
        end else begin
          n_remove++;
          unmap_range(req_data);
        end
      end
      if (rsp_valid && !rsp_stall) begin
        rsp_checked++;
        if (results_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result: %s", rsp_text(rsp_data));
        end else begin
          want = results_due.pop_front();
          if (rsp_data !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("result mismatch");
              $display("  expected %s", rsp_text(want));
              $display("  actual   %s", rsp_text(rsp_data));
            end
          end
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned ph, n;
    for (n = 0; n < TlbEntries; n++) begin
      tbl_valid[n] = 1'b0;
      tbl[n]       = '0;
    end
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed requests: extremes, errors, wrapping and the empty cases.
    queue_req(OpAdd,    32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0);
    queue_req(OpAdd,    32'h0000_0000, 32'h4000_0000, 32'h1000_0000, 1'b1);
    queue_req(OpAdd,    32'h1000_0400, 32'h2000_0123, 32'h0011_5400, 1'b0);
    queue_req(OpAdd,    32'h3000_0000, 32'h5000_0000, 32'h1000_0200, 1'b1);
    queue_req(OpAdd,    32'h0000_0123, 32'h0000_0000, 32'h0000_1000, 1'b0);
    queue_req(OpAdd,    32'h0000_0400, 32'h0000_0000, 32'h0000_03FF, 1'b0);
    queue_req(OpAdd,    32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    queue_req(OpAdd,    32'h0000_0000, 32'hFFFF_F000, 32'h0000_2000, 1'b0);
    queue_req(OpAdd,    32'hFFFF_FC00, 32'h6000_0000, 32'h0000_0800, 1'b1);
    queue_req(OpAdd,    32'h0010_0000, 32'hFFFF_0000, 32'h0010_0000, 1'b0);
    queue_req(OpRemove, 32'h0000_0000, 32'hFFF0_0000, 32'h0020_0000, 1'b0);
    queue_req(OpRemove, 32'h0000_0000, 32'h7000_0000, 32'h0000_1000, 1'b0);
    queue_req(OpRemove, 32'h0000_0000, 32'h4000_0000, 32'h1000_0000, 1'b0);
    queue_req(OpAdd,    32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0);
    queue_req(OpAdd,    32'h0000_1000, 32'h1234_5000, 32'h0000_1000, 1'b1);
    queue_req(OpRemove, 32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1);
    queue_req(OpRemove, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0);
    queue_req(OpRemove, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0);

    // Random phases: receiver idles more, then sender idles more, then neither.
    for (ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 26 : (ph == 1) ? 71 : 0;
      recv_idle_pct = (ph == 0) ? 71 : (ph == 1) ? 26 : 0;
      for (n = 0; n < RandomPerPhase; n++) req_backlog.push_back(random_req());
      while (req_backlog.size() != 0 || req_valid || results_due.size() != 0)
        @(posedge clk_i);
    end
    repeat (TailCycles) @(posedge clk_i);

    $display("Ran %0d adds (%0d ending in an error) and %0d removes.",
             n_add, n_add_err, n_remove);
    $display("Checked %0d results against the predicted table, %0d mismatches.",
             rsp_checked, mismatches);
    if (mismatches == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

// File: tlb_region_mapper_unit.f
hdl/tlbrm_pkg.sv
hdl/tlb_region_mapper_unit.sv
tb/tb_top.sv
